/* design/assert_macros.svh */
// Assertion helpers shared by vce_fifo and vce_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define VCE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// Consequent holds in the cycle after the antecedent.
`define VCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* design/vce_pkg.sv */
// ----------------------------------------------------------------------------
// vce_pkg
// Types and constants for the visual character escape unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vce_pkg;

  // mode_flags bit positions
  localparam int unsigned F_OCTAL   = 0;
  localparam int unsigned F_CSTYLE  = 1;
  localparam int unsigned F_SP      = 2;
  localparam int unsigned F_TAB     = 3;
  localparam int unsigned F_NL      = 4;
  localparam int unsigned F_SAFE    = 5;
  localparam int unsigned F_NOSLASH = 6;
  localparam int unsigned F_GLOB    = 7;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned MAX_CHARS  = 4;

  typedef struct packed {
    logic [7:0] char_in;
    logic [7:0] next_char;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_word_t;

  // One encoded item: characters in order, and index of the last one
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0]     chars;
    logic [$clog2(MAX_CHARS)-1:0]  last;
  } plan_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

/* design/vce_front.sv */
// ----------------------------------------------------------------------------
// vce_front
// Accepts input words, classifies the byte and builds its character plan.
// ----------------------------------------------------------------------------
`default_nettype none

module vce_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        mode_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire vce_pkg::in_word_t in_word_i,
  input  wire logic              fifo_full_i,
  output logic                   push_o,
  output vce_pkg::plan_t         plan_o
);

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  function automatic logic is_graphic(input logic [7:0] c);
    return (c >= 8'h21) && (c <= 8'h7E);
  endfunction

  function automatic logic is_glob(input logic [7:0] c);
    return (c == 8'h2A) || (c == 8'h3F) || (c == 8'h5B) || (c == 8'h23);
  endfunction

  function automatic logic [7:0] cstyle_letter(input logic [7:0] c);
    logic [7:0] l;
    case (c)
      8'h0A:   l = 8'h6E;  // n
      8'h0D:   l = 8'h72;  // r
      8'h08:   l = 8'h62;  // b
      8'h07:   l = 8'h61;  // a
      8'h0B:   l = 8'h76;  // v
      8'h09:   l = 8'h74;  // t
      8'h0C:   l = 8'h66;  // f
      8'h20:   l = 8'h73;  // s
      default: l = 8'h00;
    endcase
    return l;
  endfunction

  function automatic vce_pkg::plan_t encode(input logic [7:0] c, input logic [7:0] f,
                                            input logic [7:0] nx);
    vce_pkg::plan_t p;
    logic       vis;
    logic [7:0] letter;
    logic [7:0] lo;
    logic [7:0] a;
    logic [7:0] b;
    logic       slash;
    p      = '0;
    vis    = (is_graphic(c) && (!is_glob(c) || !f[vce_pkg::F_GLOB]))
          || (!f[vce_pkg::F_SP]  && c == 8'h20)
          || (!f[vce_pkg::F_TAB] && c == 8'h09)
          || (!f[vce_pkg::F_NL]  && c == 8'h0A)
          || (f[vce_pkg::F_SAFE] &&
              (c == 8'h08 || c == 8'h07 || c == 8'h0D || is_graphic(c)));
    letter = cstyle_letter(c);
    lo     = {1'b0, c[6:0]};
    slash  = !f[vce_pkg::F_NOSLASH];
    if (lo < 8'h20 || lo == CH_DEL) begin
      a = CH_CARET;
      b = (lo == CH_DEL) ? CH_QUEST : (lo + 8'h40);
    end else begin
      a = CH_DASH;
      b = lo;
    end

    if (vis) begin
      p.chars[0] = c;
      p.chars[1] = CH_BSL;
      p.last     = (c == CH_BSL && slash) ? 2'd1 : 2'd0;
    end else if (f[vce_pkg::F_CSTYLE] && letter != 8'h00) begin
      p.chars[0] = CH_BSL;
      p.chars[1] = letter;
      p.last     = 2'd1;
    end else if (f[vce_pkg::F_CSTYLE] && c == 8'h00) begin
      p.chars[0] = CH_BSL;
      p.chars[1] = CH_ZERO;
      p.chars[2] = CH_ZERO;
      p.chars[3] = CH_ZERO;
      p.last     = (nx >= 8'h30 && nx <= 8'h37) ? 2'd3 : 2'd1;
    end else if (lo == CH_SPACE || f[vce_pkg::F_OCTAL] ||
                 (f[vce_pkg::F_GLOB] && is_glob(c))) begin
      p.chars[0] = CH_BSL;
      p.chars[1] = CH_ZERO | {6'd0, c[7:6]};
      p.chars[2] = CH_ZERO | {5'd0, c[5:3]};
      p.chars[3] = CH_ZERO | {5'd0, c[2:0]};
      p.last     = 2'd3;
    end else begin
      // meta form: optional backslash, optional M, then the pair
      unique case ({slash, c[7]})
        2'b11: begin
          p.chars = {b, a, CH_M, CH_BSL};
          p.last  = 2'd3;
        end
        2'b10: begin
          p.chars = {8'h00, b, a, CH_BSL};
          p.last  = 2'd2;
        end
        2'b01: begin
          p.chars = {8'h00, b, a, CH_M};
          p.last  = 2'd2;
        end
        default: begin
          p.chars = {8'h00, 8'h00, b, a};
          p.last  = 2'd1;
        end
      endcase
    end
    return p;
  endfunction

  logic           valid_q, valid_d;
  vce_pkg::plan_t plan_q, plan_d;
  logic           accept;

  assign push_o     = valid_q && !fifo_full_i;
  assign in_stall_o = valid_q && fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign plan_o     = plan_q;

  always_comb begin
    valid_d = valid_q;
    plan_d  = plan_q;
    if (accept) begin
      valid_d = 1'b1;
      plan_d  = encode(in_word_i.char_in, mode_i, in_word_i.next_char);
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plan_q <= plan_d;
  end

endmodule

`default_nettype wire

/* design/vce_fifo.sv */
// ----------------------------------------------------------------------------
// vce_fifo
// Short queue of character plans between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vce_fifo #(
  parameter int unsigned DEPTH = vce_pkg::FIFO_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire vce_pkg::plan_t  wdata_i,
  input  wire logic            pop_i,
  output vce_pkg::plan_t       rdata_o,
  output vce_pkg::fifo_status_t status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  vce_pkg::plan_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign rdata_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `VCE_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && status_o.full))
  `VCE_ASSERT(a_no_underflow, clk_i, rst_ni, !(pop_i && status_o.empty))
  `VCE_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

/* design/vce_back.sv */
// ----------------------------------------------------------------------------
// vce_back
// Walks a character plan, sending one character a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vce_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire vce_pkg::plan_t        plan_i,
  input  wire vce_pkg::fifo_status_t fifo_st_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output vce_pkg::out_word_t         out_word_o
);

  localparam int unsigned IDX_W = $clog2(vce_pkg::MAX_CHARS);

  vce_pkg::plan_t     cur_q, cur_d;
  logic               cur_valid_q, cur_valid_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  vce_pkg::out_word_t out_q, out_d;
  logic               out_adv;
  logic               at_last;

  assign out_adv     = !out_valid_q || !out_stall_i;
  assign at_last     = (idx_q == cur_q.last);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (out_adv) begin
      out_valid_d = cur_valid_q;
      out_d       = '{out_char: cur_q.chars[idx_q], last_of_run: at_last};
      if (cur_valid_q) begin
        if (at_last) begin
          cur_valid_d = 1'b0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
    // refill the plan register as the current one drains
    if (!cur_valid_d && !fifo_st_i.empty) begin
      pop_o       = 1'b1;
      cur_d       = plan_i;
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  `VCE_ASSERT(a_idx_in_plan, clk_i, rst_ni, !cur_valid_q || (idx_q <= cur_q.last))
  `VCE_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_q && out_stall_i,
                   out_valid_q && $stable(out_q))

endmodule

`default_nettype wire

/* design/visual_char_escape_unit.sv */
// ----------------------------------------------------------------------------
// visual_char_escape_unit
// Visual encoding of one byte into one to four printable characters.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry a word holding the byte and
// the byte after it (used only for the NUL lookahead in C-style mode).
// Output channel: out_valid_o / out_stall_i carry one character a word, the
// final character of each byte flagged by last_of_run.
// mode_flags must be written through cfg_we_i / cfg_wdata_i only while idle;
// the block itself does not enforce this. The front stage encodes a byte into
// a character plan, a queue holds the plans and the back stage sends them out
// one character a cycle while the output is not stalled. A byte passes the
// front plan register, the queue, the back plan register and the output
// register. An input byte occupies the output for one word per character
// (1 to 4), and the front keeps taking words while the back is busy.
// Reset clears mode_flags and empties every stage. When the receiver stalls
// the output word holds, the queue fills and then in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module visual_char_escape_unit #(
  parameter int unsigned FIFO_DEPTH = vce_pkg::FIFO_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire vce_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output vce_pkg::out_word_t      out_word_o
);

  logic [7:0]            mode_q;
  logic                  push;
  logic                  pop;
  vce_pkg::plan_t        front_plan;
  vce_pkg::plan_t        fifo_plan;
  vce_pkg::fifo_status_t fifo_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  vce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .fifo_full_i (fifo_st.full),
    .push_o      (push),
    .plan_o      (front_plan)
  );

  vce_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (front_plan),
    .pop_i    (pop),
    .rdata_o  (fifo_plan),
    .status_o (fifo_st)
  );

  vce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .plan_i      (fifo_plan),
    .fifo_st_i   (fifo_st),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

/* verif/vce_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vce_checker
// Watches both channels and the mode register port of the escape unit. It
// predicts the character sequence of every byte taken and compares each
// character sent, in order, against that prediction.
// ----------------------------------------------------------------------------

module vce_checker import vce_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire in_word_t    in_word_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire out_word_t   out_word_i,
  output int unsigned      errors_o,
  output int unsigned      pending_o
);

  typedef logic [7:0] char_q_t [$];

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_META   = 8'h80;
  localparam logic [7:0] CH_BSLASH = "\\";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_SEVEN  = "7";

  logic [7:0] flags_q;
  out_word_t  expected_chars [$];

  function automatic logic is_graphic(input logic [7:0] c);
    return c >= 8'h21 && c <= 8'h7E;
  endfunction

  function automatic logic is_glob(input logic [7:0] c);
    return c == "*" || c == "?" || c == "[" || c == "#";
  endfunction

  function automatic logic is_visible(input logic [7:0] c, input logic [7:0] fl);
    if (is_graphic(c) && (!is_glob(c) || !fl[F_GLOB])) return 1'b1;
    if (!fl[F_SP] && c == CH_SPACE) return 1'b1;
    if (!fl[F_TAB] && c == CH_TAB) return 1'b1;
    if (!fl[F_NL] && c == CH_NL) return 1'b1;
    if (fl[F_SAFE] && (c == CH_BS || c == CH_BEL || c == CH_CR || is_graphic(c)))
      return 1'b1;
    return 1'b0;
  endfunction

  // Escape letter for C-style mode; NUL means there is none
  function automatic logic [7:0] cstyle_letter(input logic [7:0] c);
    case (c)
      CH_NL:    return "n";
      CH_CR:    return "r";
      CH_BS:    return "b";
      CH_BEL:   return "a";
      CH_VT:    return "v";
      CH_TAB:   return "t";
      CH_FF:    return "f";
      CH_SPACE: return "s";
      default:  return CH_NUL;
    endcase
  endfunction

  function automatic char_q_t encode_visual(input logic [7:0] c, input logic [7:0] nx,
                                            input logic [7:0] fl);
    char_q_t    s;
    logic [7:0] letter;
    logic [7:0] b;
    s = {};
    if (is_visible(c, fl)) begin
      s.push_back(c);
      if (c == CH_BSLASH && !fl[F_NOSLASH]) s.push_back(CH_BSLASH);
      return s;
    end
    if (fl[F_CSTYLE]) begin
      letter = cstyle_letter(c);
      if (letter != CH_NUL) begin
        s.push_back(CH_BSLASH);
        s.push_back(letter);
        return s;
      end
      if (c == CH_NUL) begin
        s.push_back(CH_BSLASH);
        s.push_back(CH_ZERO);
        // a following octal digit would merge into a short escape
        if (nx >= CH_ZERO && nx <= CH_SEVEN) begin
          s.push_back(CH_ZERO);
          s.push_back(CH_ZERO);
        end
        return s;
      end
    end
    if (c[6:0] == CH_SPACE[6:0] || fl[F_OCTAL] || (fl[F_GLOB] && is_glob(c))) begin
      s.push_back(CH_BSLASH);
      s.push_back(CH_ZERO + {6'd0, c[7:6]});
      s.push_back(CH_ZERO + {5'd0, c[5:3]});
      s.push_back(CH_ZERO + {5'd0, c[2:0]});
      return s;
    end
    if (!fl[F_NOSLASH]) s.push_back(CH_BSLASH);
    b = c;
    if (b[7]) begin
      b = b & ~CH_META;
      s.push_back("M");
    end
    if (b < CH_SPACE || b == CH_DEL) begin
      s.push_back("^");
      s.push_back((b == CH_DEL) ? 8'("?") : b + 8'h40);
    end else begin
      s.push_back("-");
      s.push_back(b);
    end
    return s;
  endfunction

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    char_q_t   seq;
    out_word_t want;
    if (!rst_ni) begin
      flags_q = 8'h00;
      expected_chars.delete();
    end else begin
      if (cfg_we_i) flags_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        seq = encode_visual(in_word_i.char_in, in_word_i.next_char, flags_q);
        foreach (seq[k])
          expected_chars.push_back(out_word_t'{out_char: seq[k],
                                               last_of_run: (k == seq.size() - 1)});
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual char %02h last %0b",
                   $time, out_word_i.out_char, out_word_i.last_of_run);
          errors_o++;
        end else begin
          want = expected_chars.pop_front();
          if (out_word_i.out_char !== want.out_char) begin
            $display("%0t: out_char mismatch, expected %02h actual %02h",
                     $time, want.out_char, out_word_i.out_char);
            errors_o++;
          end
          if (out_word_i.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run mismatch, expected %0b actual %0b",
                     $time, want.last_of_run, out_word_i.last_of_run);
            errors_o++;
          end
        end
      end
    end
    pending_o = expected_chars.size();
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the visual character escape unit. Directed bytes cover the
// escape forms, then random bytes run under a series of mode settings with
// random gaps and stalls on both channels; a checker compares the output.
// ----------------------------------------------------------------------------

module tb_top;
  import vce_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned HOLD_AFTER     = 120;
  localparam int unsigned WORDS_PER_MODE = 40;
  localparam int unsigned SETTLE_CYCLES  = 8;

  localparam logic [7:0] OPT_OCTAL   = 8'h01 << F_OCTAL;
  localparam logic [7:0] OPT_CSTYLE  = 8'h01 << F_CSTYLE;
  localparam logic [7:0] OPT_SP      = 8'h01 << F_SP;
  localparam logic [7:0] OPT_TAB     = 8'h01 << F_TAB;
  localparam logic [7:0] OPT_NL      = 8'h01 << F_NL;
  localparam logic [7:0] OPT_SAFE    = 8'h01 << F_SAFE;
  localparam logic [7:0] OPT_NOSLASH = 8'h01 << F_NOSLASH;
  localparam logic [7:0] OPT_GLOB    = 8'h01 << F_GLOB;

  localparam logic [7:0] ODD_BYTES [12] = '{"*", "?", "[", "#", " ", "\\",
                                             8'h7F, 8'hA0, 8'hFF, 8'h0D, 8'h08, 8'h07};

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  int unsigned errors;
  int unsigned pending;
  int unsigned words_sent;
  int unsigned cycles;
  logic        calm;

  visual_char_escape_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  vce_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: short stall bursts, one long hold-off to back the unit up
  initial begin
    logic held;
    held      = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && words_sent >= HOLD_AFTER) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end
    end
  end

  task automatic send_word(input logic [7:0] c, input logic [7:0] nx);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = in_word_t'{char_in: c, next_char: nx};
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic set_mode(input logic [7:0] flags);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = flags;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic send_random_word();
    logic [7:0] c;
    logic [7:0] nx;
    case ($urandom_range(0, 5))
      0, 1:    c = 8'($urandom_range(0, 255));
      2:       c = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 31))};
      3:       c = ODD_BYTES[$urandom_range(0, 11)];
      4:       c = 8'h00;
      default: c = {1'($urandom_range(0, 1)), 7'($urandom_range(8'h21, 8'h7E))};
    endcase
    // digits and their neighbours exercise the NUL lookahead boundary
    if ($urandom_range(0, 1) == 0) nx = 8'($urandom_range(0, 255));
    else nx = 8'($urandom_range(8'h2E, 8'h39));
    send_word(c, nx);
  endtask

  initial begin
    logic [7:0] modes [8];
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = 8'h00;
    in_valid   = 1'b0;
    in_word    = '0;
    words_sent = 0;
    calm       = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset mode: meta and control forms, backslash doubling, octal for meta space
    send_word(8'h00, "0");
    send_word(8'h7F, 8'h00);
    send_word(8'hFF, 8'hFF);
    send_word(8'hA0, "A");
    send_word("\\", "x");
    send_word("A", 8'hFF);
    send_word(8'hC1, 8'h00);
    send_word(" ", 8'h00);

    set_mode(OPT_CSTYLE | OPT_SP | OPT_TAB | OPT_NL);
    send_word(8'h00, "7");
    send_word(8'h00, "8");
    send_word(8'h00, "/");
    send_word(" ", 8'h00);
    send_word(8'h0A, 8'h00);
    send_word(8'h0D, 8'h00);
    send_word(8'h08, 8'h00);
    send_word(8'h07, 8'h00);
    send_word(8'h0B, 8'h00);
    send_word(8'h0C, 8'h00);

    set_mode(OPT_GLOB | OPT_NOSLASH);
    send_word("*", 8'h00);
    send_word("\\", 8'h00);
    send_word(8'h01, 8'h00);
    send_word(8'h80, 8'h00);

    // safe lets bell and glob characters through; octal takes the rest
    set_mode(OPT_SAFE | OPT_GLOB | OPT_OCTAL);
    send_word(8'h07, 8'h00);
    send_word("?", 8'h00);
    send_word(8'h01, 8'h00);
    send_word(8'hFF, 8'h00);

    modes = '{8'hFF, OPT_GLOB, OPT_SAFE | OPT_GLOB | OPT_NOSLASH, OPT_NOSLASH,
              OPT_OCTAL | OPT_CSTYLE, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'h00};
    foreach (modes[m]) begin
      set_mode(modes[m]);
      if (m == 7) calm = 1'b1;
      repeat (WORDS_PER_MODE) send_random_word();
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/vce_pkg.sv
design/vce_front.sv
design/vce_fifo.sv
design/vce_back.sv
design/visual_char_escape_unit.sv
verif/vce_checker.sv
verif/tb_top.sv
